// ----- hw/rtl/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// stc_pkg
// shared constants, types and helpers for the scrolling text console
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stc_pkg;

  // default geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // field widths
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int CELL_W   = CHAR_W + COLOR_W;
  localparam int SROW_W   = 5;
  localparam int SCOL_W   = 7;
  localparam int CURSOR_W = 7;
  localparam int HEAD_W   = 5;

  // character codes
  localparam logic [CHAR_W-1:0]  BLANK_CHAR  = 8'h20;
  localparam logic [CHAR_W-1:0]  LINE_FEED   = 8'h0A;
  localparam logic [CHAR_W-1:0]  BACK_SPACE  = 8'h08;
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

  // request codes
  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic [CHAR_W-1:0]   cell_char;
    logic [COLOR_W-1:0]  cell_color;
    logic [CURSOR_W-1:0] cursor_column;
    logic [HEAD_W-1:0]   head_ring_row;
  } stc_rsp_t;

  // attribute in the high byte, character in the low byte
  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                 input logic [COLOR_W-1:0] color);
    return {color, ch};
  endfunction

endpackage

// ----- hw/rtl/stc_if.sv -----
// ----------------------------------------------------------------------------
// stc_if
// valid/ready channels of the console: request and response
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stc_req_if import stc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [CHAR_W-1:0] char_code;
  logic [SROW_W-1:0] screen_row;
  logic [SCOL_W-1:0] screen_col;

  modport source(output valid, req_type, char_code, screen_row, screen_col, input ready);
  modport sink(input valid, req_type, char_code, screen_row, screen_col, output ready);
endinterface

interface stc_rsp_if import stc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHAR_W-1:0]   cell_char;
  logic [COLOR_W-1:0]  cell_color;
  logic [CURSOR_W-1:0] cursor_column;
  logic [HEAD_W-1:0]   head_ring_row;

  modport source(output valid, cell_char, cell_color, cursor_column, head_ring_row,
                 input ready);
  modport sink(input valid, cell_char, cell_color, cursor_column, head_ring_row,
               output ready);
endinterface

// ----- hw/rtl/stc_cell_ram.sv -----
// ----------------------------------------------------------------------------
// stc_cell_ram
// cell store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stc_cell_ram import stc_pkg::*; #(
  parameter int DEPTH = COLUMNS_DEF * ROWS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/stc_ctrl.sv -----
// ----------------------------------------------------------------------------
// stc_ctrl
// request sequencer: cursor, ring head, memory access and row clearing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stc_ctrl import stc_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF,
  parameter int AW      = $clog2(COLUMNS * ROWS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [COLOR_W-1:0] text_color,
  stc_req_if.sink            in_req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output stc_rsp_t           rsp,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [CELL_W-1:0]  mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  logic [CELL_W-1:0]  mem_rdata
);

  localparam int DEPTH = COLUMNS * ROWS;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int RSW   = RW + 1;

  typedef enum logic [4:0] {
    ST_CLR_ALL = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_CLR_ROW = 5'b00100,
    ST_READ    = 5'b01000,
    ST_RESP    = 5'b10000
  } stc_state_t;

  stc_state_t        state_r, state_nxt;
  logic [RW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     cursor_r, cursor_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [CW-1:0]     clr_col_r, clr_col_nxt;
  logic [CELL_W-1:0] cell_r, cell_nxt;

  logic [RW-1:0]  head_inc;
  logic [RW-1:0]  bs_head;
  logic [CW-1:0]  bs_col;
  logic [RSW-1:0] ring_sum;
  logic [RW-1:0]  ring_row;
  logic           rd_in_range;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                              input logic [CW-1:0] col);
    return AW'(AW'(row) * AW'(COLUMNS)) + AW'(col);
  endfunction

  assign head_inc = (head_r == RW'(ROWS - 1)) ? '0 : head_r + 1'b1;
  assign bs_col   = (cursor_r == '0) ? CW'(COLUMNS - 1) : cursor_r - 1'b1;
  assign bs_head  = (cursor_r != '0) ? head_r :
                    (head_r == '0)   ? RW'(ROWS - 1) : head_r - 1'b1;

  // screen row r shows ring row (head + r + 1) mod ROWS
  assign rd_in_range = (9'(in_req.screen_row) < 9'(ROWS)) &&
                       (9'(in_req.screen_col) < 9'(COLUMNS));
  assign ring_sum    = RSW'(head_r) + RSW'(in_req.screen_row) + RSW'(1);
  assign ring_row    = (ring_sum >= RSW'(ROWS)) ? RW'(ring_sum - RSW'(ROWS)) : RW'(ring_sum);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    cursor_nxt   = cursor_r;
    clr_addr_nxt = clr_addr_r;
    clr_col_nxt  = clr_col_r;
    cell_nxt     = cell_r;
    mem_we       = 1'b0;
    mem_waddr    = cell_addr(head_r, cursor_r);
    mem_wdata    = make_cell(BLANK_CHAR, text_color);
    mem_re       = 1'b0;
    mem_raddr    = cell_addr(ring_row, CW'(in_req.screen_col));

    unique case (state_r)
      ST_CLR_ALL: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = make_cell(BLANK_CHAR, RESET_COLOR);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_req.valid) begin
          cell_nxt = '0;
          if (in_req.req_type == REQ_READ) begin
            if (rd_in_range) begin
              mem_re    = 1'b1;
              state_nxt = ST_READ;
            end else begin
              state_nxt = ST_RESP;
            end
          end else begin
            case (in_req.char_code)
              LINE_FEED: begin
                cursor_nxt  = '0;
                head_nxt    = head_inc;
                clr_col_nxt = '0;
                state_nxt   = ST_CLR_ROW;
              end
              BACK_SPACE: begin
                mem_we     = 1'b1;
                mem_waddr  = cell_addr(bs_head, bs_col);
                cursor_nxt = bs_col;
                head_nxt   = bs_head;
                state_nxt  = ST_RESP;
              end
              default: begin
                mem_we    = 1'b1;
                mem_wdata = make_cell(in_req.char_code, text_color);
                if (cursor_r == CW'(COLUMNS - 1)) begin
                  // wrap past the last column starts a new line
                  cursor_nxt  = '0;
                  head_nxt    = head_inc;
                  clr_col_nxt = '0;
                  state_nxt   = ST_CLR_ROW;
                end else begin
                  cursor_nxt = cursor_r + 1'b1;
                  state_nxt  = ST_RESP;
                end
              end
            endcase
          end
        end
      end
      ST_CLR_ROW: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(head_r, clr_col_r);
        if (clr_col_r == CW'(COLUMNS - 1)) begin
          state_nxt = ST_RESP;
        end else begin
          clr_col_nxt = clr_col_r + 1'b1;
        end
      end
      ST_READ: begin
        cell_nxt  = mem_rdata;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (rsp_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR_ALL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR_ALL;
      head_r     <= '0;
      cursor_r   <= '0;
      clr_addr_r <= '0;
      clr_col_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      cursor_r   <= cursor_nxt;
      clr_addr_r <= clr_addr_nxt;
      clr_col_r  <= clr_col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign in_req.ready = (state_r == ST_IDLE);
  assign rsp_valid    = (state_r == ST_RESP);
  assign rsp = '{cell_char:     cell_r[CHAR_W-1:0],
                 cell_color:    cell_r[CELL_W-1:CHAR_W],
                 cursor_column: CURSOR_W'(cursor_r),
                 head_ring_row: HEAD_W'(head_r)};

  a_read_keeps_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready && in_req.req_type == REQ_READ)
      |=> $stable(head_r) && $stable(cursor_r))
    else $error("read transaction moved the cursor");

  a_line_feed_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready && in_req.req_type == REQ_PUT &&
     in_req.char_code == LINE_FEED)
      |=> (state_r == ST_CLR_ROW) && (cursor_r == '0) && (clr_col_r == '0))
    else $error("line feed did not start a row clear");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (9'(cursor_r) < 9'(COLUMNS)) && (7'(head_r) < 7'(ROWS)))
    else $error("cursor outside the screen");

  a_no_write_on_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP || state_r == ST_READ) |-> !mem_we)
    else $error("memory write while a response is pending");

endmodule

// ----- hw/rtl/scrolling_text_console.sv -----
// ----------------------------------------------------------------------------
// scrolling_text_console
// character-cell text console kept as a ring of rows in one cell memory.
// A put transaction writes a character at the cursor (line feed starts and
// blanks a new ring row, backspace steps back and blanks a cell); a read
// transaction returns the cell shown at a screen position, where the bottom
// screen row is the head ring row. Every transaction yields one response that
// also carries the cursor column and head ring row. A printable put or
// backspace writes its cell and then responds, a read first waits for the
// registered memory read data, and a line feed or a put that wraps the last
// column first blanks the new ring row through the single write port of the
// cell memory, one cell per cycle. After reset the whole memory is filled
// with spaces in color 7 while in_req.ready stays low; cfg writes are taken
// at any time. The response sits in an output register, so the next request
// is taken while a response waits. cfg_wdata sets the attribute byte of new
// and blanked cells and is to be written only while no transaction is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scrolling_text_console import stc_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  stc_req_if.sink            in_req,
  stc_rsp_if.source          out_rsp,
  input  logic               cfg_we,
  input  logic [COLOR_W-1:0] cfg_wdata
);

  localparam int DEPTH = COLUMNS * ROWS;
  localparam int AW    = $clog2(DEPTH);

  // text color register
  logic [COLOR_W-1:0] text_color_r;

  // sequencer to output register
  logic     rsp_valid;
  logic     rsp_ready;
  stc_rsp_t rsp;

  // cell memory ports
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // output register
  logic     out_valid_r;
  stc_rsp_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= RESET_COLOR;
    end else if (cfg_we) begin
      text_color_r <= cfg_wdata;
    end
  end

  stc_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .text_color (text_color_r),
    .in_req     (in_req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  stc_cell_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_cell_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // the output register takes a new response when empty or being drained
  assign rsp_ready = !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_r <= rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      out_data_r <= rsp;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.cell_char     = out_data_r.cell_char;
  assign out_rsp.cell_color    = out_data_r.cell_color;
  assign out_rsp.cursor_column = out_data_r.cursor_column;
  assign out_rsp.head_ring_row = out_data_r.head_ring_row;

endmodule

// ----- sim/scrolling_text_console_tb.sv -----
// ----------------------------------------------------------------------------
// scrolling_text_console_tb
// self-checking bench for the ring-of-rows text console: a directed table
// walks the wrap, blanking and out-of-range corners, then random puts and
// reads run under several text colors, all scored against a cell-level
// shadow of the screen with random stalls on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scrolling_text_console_tb;
  import stc_pkg::*;

  localparam int COLUMNS         = COLUMNS_DEF;
  localparam int ROWS            = ROWS_DEF;
  localparam int PHASES          = 6;
  localparam int PHASE_ITEMS     = 325;
  localparam int SETTLE_CYCLES   = 100;    // beyond the longest line blank
  localparam int HOLD_CYCLES     = 400;    // long receiver hold-off
  localparam int WATCHDOG_LIMIT  = 20000;  // covers the clearing pass too
  localparam int SCRIPT_LEN      = 25;
  localparam logic TYPED         = 1'b1;
  localparam logic PREDICTED     = 1'b0;

  typedef struct packed {
    logic                req_type;
    logic [CHAR_W-1:0]   char_code;
    logic [SROW_W-1:0]   screen_row;
    logic [SCOL_W-1:0]   screen_col;
  } console_req_t;

  // one row of the directed walk; typed rows carry their own answer
  typedef struct packed {
    console_req_t req;
    logic         typed;
    stc_rsp_t     want;
  } script_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [COLOR_W-1:0] cfg_wdata;

  stc_req_if req_ch ();
  stc_rsp_if rsp_ch ();

  scrolling_text_console DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_ch),
    .out_rsp  (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // shadow of the screen: ring of cells, head ring row, cursor and color
  // ---------------------------------------------------------------------------
  logic [CELL_W-1:0]  shadow_cells [ROWS*COLUMNS];
  int                 shadow_head;
  int                 shadow_cursor;
  logic [COLOR_W-1:0] shadow_color;

  stc_rsp_t awaited_rsp [$];
  int       error_count;
  int       rsp_seen;

  // next ring row, blanked in the current color
  function automatic void shadow_new_line();
    shadow_cursor = 0;
    shadow_head   = (shadow_head + 1) % ROWS;
    for (int x = 0; x < COLUMNS; x++) begin
      shadow_cells[shadow_head*COLUMNS + x] = {shadow_color, BLANK_CHAR};
    end
  endfunction

  // applies one transaction to the shadow and returns the response it owes
  function automatic stc_rsp_t console_response(console_req_t r);
    stc_rsp_t rsp;
    int       idx;
    rsp = '0;
    if (r.req_type == REQ_PUT) begin
      if (r.char_code == LINE_FEED) begin
        shadow_new_line();
      end else if (r.char_code == BACK_SPACE) begin
        // step back, wrapping to the last column of the previous ring row
        if (shadow_cursor == 0) begin
          shadow_cursor = COLUMNS - 1;
          shadow_head   = (shadow_head == 0) ? ROWS - 1 : shadow_head - 1;
        end else begin
          shadow_cursor--;
        end
        shadow_cells[shadow_head*COLUMNS + shadow_cursor] = {shadow_color, BLANK_CHAR};
      end else begin
        shadow_cells[shadow_head*COLUMNS + shadow_cursor] = {shadow_color, r.char_code};
        shadow_cursor++;
        // running off the last column starts a new line
        if (shadow_cursor >= COLUMNS) shadow_new_line();
      end
    end else if (int'(r.screen_row) < ROWS && int'(r.screen_col) < COLUMNS) begin
      // bottom screen row is the head ring row
      idx = ((shadow_head + int'(r.screen_row) + 1) % ROWS) * COLUMNS + int'(r.screen_col);
      rsp.cell_char  = shadow_cells[idx][CHAR_W-1:0];
      rsp.cell_color = shadow_cells[idx][CELL_W-1:CHAR_W];
    end
    rsp.cursor_column = shadow_cursor[CURSOR_W-1:0];
    rsp.head_ring_row = shadow_head[HEAD_W-1:0];
    return rsp;
  endfunction

  // mostly short gaps, a few long ones, many zero
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // idle cycles with junk on the payload, valid low
  task automatic idle_sender(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= 1'($urandom);
      req_ch.char_code  <= 8'($urandom);
      req_ch.screen_row <= 5'($urandom);
      req_ch.screen_col <= 7'($urandom);
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // offers one transaction and holds it until accepted; valid stays high after
  task automatic offer_request(console_req_t r, logic typed, stc_rsp_t want);
    stc_rsp_t predicted;
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= r.req_type;
    req_ch.char_code  <= r.char_code;
    req_ch.screen_row <= r.screen_row;
    req_ch.screen_col <= r.screen_col;
    do @(posedge clk); while (!req_ch.ready);
    predicted = console_response(r);
    awaited_rsp.push_back(typed ? want : predicted);
  endtask

  // drains all responses and lets the block go quiet before a color change
  task automatic wait_quiet();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_text_color(logic [COLOR_W-1:0] color);
    wait_quiet();
    @(negedge clk);
    cfg_we       <= 1'b1;
    cfg_wdata    <= color;
    shadow_color  = color;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random transaction; lf_pct and bs_pct shape the put mix of a phase
  function automatic console_req_t random_request(int lf_pct, int bs_pct);
    console_req_t r;
    int           k;
    r.req_type   = ($urandom_range(0, 99) < 40) ? REQ_READ : REQ_PUT;
    r.char_code  = 8'($urandom);
    r.screen_row = 5'($urandom);
    r.screen_col = 7'($urandom);
    if (r.req_type == REQ_PUT) begin
      k = $urandom_range(0, 99);
      if (k < lf_pct) r.char_code = LINE_FEED;
      else if (k < lf_pct + bs_pct) r.char_code = BACK_SPACE;
    end else if ($urandom_range(0, 9) != 0) begin
      // in range, leaning toward the rows near the cursor
      r.screen_row = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(ROWS - 3, ROWS - 1))
                                                 : 5'($urandom_range(0, ROWS - 1));
      r.screen_col = 7'($urandom_range(0, COLUMNS - 1));
    end
    return r;
  endfunction

  // directed walk from reset: color 7, head 0, cursor 0
  script_row_t script [SCRIPT_LEN] = '{
    // reads from a fresh screen, both corners
    '{'{REQ_READ, 8'h00, 5'd0,  7'd0},   TYPED, '{BLANK_CHAR, RESET_COLOR, 7'd0, 5'd0}},
    '{'{REQ_READ, 8'hFF, 5'd24, 7'd79},  TYPED, '{BLANK_CHAR, RESET_COLOR, 7'd0, 5'd0}},
    // reads outside the screen answer zero
    '{'{REQ_READ, 8'h00, 5'd31, 7'd127}, TYPED, '{8'h00, 8'h00, 7'd0, 5'd0}},
    '{'{REQ_READ, 8'h00, 5'd25, 7'd0},   TYPED, '{8'h00, 8'h00, 7'd0, 5'd0}},
    '{'{REQ_READ, 8'h00, 5'd0,  7'd80},  TYPED, '{8'h00, 8'h00, 7'd0, 5'd0}},
    // backspace from the home cell wraps to the end of the last ring row
    '{'{REQ_PUT, BACK_SPACE, 5'd31, 7'd127}, TYPED, '{8'h00, 8'h00, 7'd79, 5'd24}},
    // a put in the last column wraps into a new line
    '{'{REQ_PUT, 8'h41, 5'd0, 7'd0},     TYPED, '{8'h00, 8'h00, 7'd0, 5'd0}},
    // a read carrying a line-feed byte is still only a read
    '{'{REQ_READ, LINE_FEED, 5'd23, 7'd79}, TYPED, '{8'h41, RESET_COLOR, 7'd0, 5'd0}},
    '{'{REQ_PUT, 8'h00, 5'd0, 7'd0},     TYPED, '{8'h00, 8'h00, 7'd1, 5'd0}},
    '{'{REQ_PUT, 8'hFF, 5'd0, 7'd0},     TYPED, '{8'h00, 8'h00, 7'd2, 5'd0}},
    '{'{REQ_READ, 8'h00, 5'd24, 7'd0},   TYPED, '{8'h00, RESET_COLOR, 7'd2, 5'd0}},
    '{'{REQ_READ, 8'h00, 5'd24, 7'd1},   TYPED, '{8'hFF, RESET_COLOR, 7'd2, 5'd0}},
    // backspace mid-row blanks the cell behind the cursor
    '{'{REQ_PUT, BACK_SPACE, 5'd0, 7'd0}, TYPED, '{8'h00, 8'h00, 7'd1, 5'd0}},
    '{'{REQ_READ, 8'h00, 5'd24, 7'd1},   TYPED, '{BLANK_CHAR, RESET_COLOR, 7'd1, 5'd0}},
    '{'{REQ_PUT, LINE_FEED, 5'd0, 7'd0}, TYPED, '{8'h00, 8'h00, 7'd0, 5'd1}},
    '{'{REQ_READ, 8'h00, 5'd23, 7'd0},   TYPED, '{8'h00, RESET_COLOR, 7'd0, 5'd1}},
    '{'{REQ_PUT, 8'h7F, 5'd0, 7'd0},     TYPED, '{8'h00, 8'h00, 7'd1, 5'd1}},
    '{'{REQ_PUT, 8'h80, 5'd0, 7'd0},     TYPED, '{8'h00, 8'h00, 7'd2, 5'd1}},
    '{'{REQ_READ, 8'h00, 5'd24, 7'd0},   TYPED, '{8'h7F, RESET_COLOR, 7'd2, 5'd1}},
    // backspace back across the row start into ring row 0
    '{'{REQ_PUT, BACK_SPACE, 5'd0, 7'd0}, TYPED, '{8'h00, 8'h00, 7'd1, 5'd1}},
    '{'{REQ_PUT, BACK_SPACE, 5'd0, 7'd0}, TYPED, '{8'h00, 8'h00, 7'd0, 5'd1}},
    '{'{REQ_PUT, BACK_SPACE, 5'd0, 7'd0}, TYPED, '{8'h00, 8'h00, 7'd79, 5'd0}},
    '{'{REQ_READ, 8'h00, 5'd24, 7'd79},  TYPED, '{BLANK_CHAR, RESET_COLOR, 7'd79, 5'd0}},
    '{'{REQ_READ, BACK_SPACE, 5'd0, 7'd40}, PREDICTED, '0},
    '{'{REQ_READ, 8'h00, 5'd15, 7'd1},   PREDICTED, '0}
  };

  // per-phase text color and put mix
  logic [COLOR_W-1:0] phase_color [PHASES];
  int                 phase_lf    [PHASES] = '{2, 10, 0, 5, 20, 1};
  int                 phase_bs    [PHASES] = '{10, 5, 20, 2, 10, 30};

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_PUT;
    req_ch.char_code  = '0;
    req_ch.screen_row = '0;
    req_ch.screen_col = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    rst_n             = 1'b0;
    error_count       = 0;

    // shadow starts as the post-reset screen
    for (int i = 0; i < ROWS*COLUMNS; i++) shadow_cells[i] = {RESET_COLOR, BLANK_CHAR};
    shadow_head   = 0;
    shadow_cursor = 0;
    shadow_color  = RESET_COLOR;

    phase_color = '{8'h00, 8'hFF, 8'($urandom), 8'hA5, 8'h5A, 8'($urandom)};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed walk in the reset color
    foreach (script[i]) begin
      idle_sender(pick_gap());
      offer_request(script[i].req, script[i].typed, script[i].want);
    end

    // random phases, each under its own color
    for (int p = 0; p < PHASES; p++) begin
      set_text_color(phase_color[p]);
      repeat (PHASE_ITEMS) begin
        idle_sender(pick_gap());
        offer_request(random_request(phase_lf[p], phase_bs[p]), PREDICTED, '0);
      end
    end

    wait_quiet();
    if (error_count == 0) begin
      $display("scrolling_text_console verification clean");
    end else begin
      $display("scrolling_text_console verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // response side: random stalls, plus two long hold-offs to back up the input
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    int run_left;
    int holds_done;
    stall_left   = 0;
    run_left     = 0;
    holds_done   = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ((holds_done == 0 && rsp_seen >= 700) || (holds_done == 1 && rsp_seen >= 1500)) begin
        holds_done++;
        stall_left = HOLD_CYCLES;
        run_left   = 0;
      end
      if (stall_left == 0 && run_left == 0) begin
        run_left   = $urandom_range(1, 24);
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        run_left--;
      end
    end
  end

  // scoreboard: each response against the oldest outstanding expectation
  initial begin
    stc_rsp_t want;
    rsp_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
        rsp_seen++;
        if (awaited_rsp.size() == 0) begin
          $error("response transaction with nothing outstanding");
          error_count++;
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp_ch.cell_char !== want.cell_char) begin
            $error("cell_char expected %0h got %0h", want.cell_char, rsp_ch.cell_char);
            error_count++;
          end
          if (rsp_ch.cell_color !== want.cell_color) begin
            $error("cell_color expected %0h got %0h", want.cell_color, rsp_ch.cell_color);
            error_count++;
          end
          if (rsp_ch.cursor_column !== want.cursor_column) begin
            $error("cursor_column expected %0d got %0d", want.cursor_column,
                   rsp_ch.cursor_column);
            error_count++;
          end
          if (rsp_ch.head_ring_row !== want.head_ring_row) begin
            $error("head_ring_row expected %0d got %0d", want.head_ring_row,
                   rsp_ch.head_ring_row);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog: too long without any transaction on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("scrolling_text_console verification failed");
    $finish;
  end

endmodule
